FILE: hdl/zscore_pairwise_distance_macros.svh
// assertion macros used by the checker of the z-score distance block
// expects clk and arst_n in the scope where a macro is used
`ifndef ZSCORE_PAIRWISE_DISTANCE_MACROS_SVH
`define ZSCORE_PAIRWISE_DISTANCE_MACROS_SVH

// property that holds on every edge out of reset
`define ZPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("zpd check failed");

// consequent must hold in the cycle after the antecedent
`define ZPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zpd check failed");

`endif

FILE: hdl/zpd_pkg.sv
// shared widths, codes and control types of the z-score distance block
// used by the controller, datapath, top level and checker
`timescale 1ns / 1ps

package zpd_pkg;

	localparam int MAX_LOCATIONS = 1024;
	localparam int ADDR_W = $clog2(MAX_LOCATIONS);
	localparam int CNT_W = ADDR_W + 1;
	localparam int DATA_W = 32;
	localparam int SUM_W = DATA_W + CNT_W;
	localparam int ABS_W = SUM_W - 1;
	localparam int SQP_W = 2 * DATA_W;
	localparam int SQ_W = 2 * DATA_W - 2 + CNT_W;
	localparam int D_W = CNT_W + SQ_W;
	localparam int RT_W = (D_W + DATA_W + 1) / 2;
	localparam int X_W = 2 * RT_W;
	localparam int SREM_W = RT_W + 4;
	localparam int PROD_W = CNT_W + 1 + DATA_W;
	localparam int NUM_W = PROD_W + 1;
	localparam int MAG_W = PROD_W;
	localparam int DVD_W = MAG_W + DATA_W + 1;
	localparam int DREM_W = RT_W + 1;
	localparam int QUO_W = DATA_W + 1;
	localparam int STEP_W = $clog2(DVD_W + 1);

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] CFG_NORM_ADDR = PADDR_W'(0);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [DATA_W-1:0] Z_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Z_NEG_MAX = 32'h8000_0000;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_FINISH = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		RES_FULL,
		RES_FINISH,
		RES_QUERY
	} res_kind_t;

	typedef enum logic {
		WR_ZSCORE,
		WR_MARK
	} wr_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RESULT,
		S_SUM,
		S_SUM_TAIL,
		S_CHECK,
		S_MUL_NQ,
		S_MUL_SWAP,
		S_MUL_SS,
		S_DZERO,
		S_MARK,
		S_SQRT,
		S_NORM_RD,
		S_NORM_WAIT,
		S_NORM_LOAD,
		S_NORM_DIV,
		S_NORM_WB
	} state_t;

	typedef struct packed {
		logic load_en;
		logic query_en;
		logic close_en;
		logic sum_clr;
		logic sum_rd;
		logic mul_ld_nq;
		logic mul_ld_ss;
		logic mul_step;
		logic sqrt_ld;
		logic sqrt_step;
		logic norm_rd;
		logic prod_en;
		logic div_ld;
		logic div_step;
		logic wr_en;
		wr_src_t wr_src;
		logic [ADDR_W-1:0] idx;
		logic res_load;
		res_kind_t res_kind;
	} zpd_cmd_t;

	typedef struct packed {
		logic load_full;
		logic [CNT_W-1:0] count;
		logic n_zero;
		logic d_zero;
		logic rd_missing;
		logic out_free;
	} zpd_stat_t;

endpackage

FILE: hdl/zscore_pairwise_distance.sv
// top level of the z-score distance block: config register and wiring
// depends on zpd_pkg, zpd_ctrl and zpd_datapath
`timescale 1ns / 1ps

// One item is taken at a time; the input stalls until the item is done.
// A load into a store with room is taken without a stall; a load into a
// full store, a query and a finish wait in a result state until the
// output register is free. A finish with normalization on runs the
// statistics pass and, unless every sample is missing, the n*Q - S*S
// shift-add multiply, the 58-step square root and a bit-serial divide
// for every non-missing sample; the bit-serial divider dominates. When the
// deviation is zero the last pass instead marks every sample missing at
// one entry per cycle. Results sit in an output register, so the next
// item is taken while a result waits to be transferred.
module zscore_pairwise_distance import zpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     sample_missing,
	input  logic [ADDR_W-1:0]        loc_a,
	input  logic [ADDR_W-1:0]        loc_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [DATA_W-1:0]        distance,
	output logic                     distance_missing,
	output logic [1:0]               status,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic norm_en_q;
	zpd_cmd_t cmd;
	zpd_stat_t st;

	assign pready = 1'b1;
	assign prdata = (paddr == CFG_NORM_ADDR) ? {31'b0, norm_en_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == CFG_NORM_ADDR) begin
			norm_en_q <= pwdata[0];
		end
	end

	zpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.norm_en  (norm_en_q),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	zpd_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.sample           (sample),
		.sample_missing   (sample_missing),
		.loc_a            (loc_a),
		.loc_b            (loc_b),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.distance         (distance),
		.distance_missing (distance_missing),
		.status           (status)
	);

endmodule

FILE: hdl/zpd_ctrl.sv
// sequencer of the z-score distance block: item decode and the finish passes
// depends on zpd_pkg; drives the datapath through zpd_cmd_t
`timescale 1ns / 1ps

module zpd_ctrl import zpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        func,
	input  logic              norm_en,
	output logic              in_stall,
	input  zpd_stat_t         st,
	output zpd_cmd_t          cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] idx_q;
	logic [STEP_W-1:0] step_q;
	res_kind_t kind_q;
	logic idx_end;

	assign idx_end = idx_q == st.count;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_LOAD:   if (st.load_full) state_d = S_RESULT;
						FUNC_FINISH: state_d = norm_en ? S_SUM : S_RESULT;
						FUNC_QUERY:  state_d = S_RESULT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_RESULT:    if (st.out_free) state_d = S_IDLE;
			S_SUM:       if (idx_end) state_d = S_SUM_TAIL;
			S_SUM_TAIL:  if (step_q == STEP_W'(1)) state_d = S_CHECK;
			S_CHECK:     state_d = st.n_zero ? S_RESULT : S_MUL_NQ;
			S_MUL_NQ:    if (step_q == STEP_W'(CNT_W - 1)) state_d = S_MUL_SWAP;
			S_MUL_SWAP:  state_d = S_MUL_SS;
			S_MUL_SS:    if (step_q == STEP_W'(ABS_W - 1)) state_d = S_DZERO;
			S_DZERO:     state_d = st.d_zero ? S_MARK : S_SQRT;
			S_MARK:      if (idx_end) state_d = S_RESULT;
			S_SQRT:      if (step_q == STEP_W'(RT_W - 1)) state_d = S_NORM_RD;
			S_NORM_RD:   state_d = idx_end ? S_RESULT : S_NORM_WAIT;
			S_NORM_WAIT: state_d = st.rd_missing ? S_NORM_RD : S_NORM_LOAD;
			S_NORM_LOAD: state_d = S_NORM_DIV;
			S_NORM_DIV:  if (step_q == STEP_W'(DVD_W - 1)) state_d = S_NORM_WB;
			S_NORM_WB:   state_d = S_NORM_RD;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q[ADDR_W-1:0];
		cmd.res_kind = kind_q;
		cmd.wr_src = WR_ZSCORE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_LOAD:   cmd.load_en = 1'b1;
						FUNC_FINISH: begin
							cmd.close_en = 1'b1;
							cmd.sum_clr = norm_en;
						end
						FUNC_QUERY:  cmd.query_en = 1'b1;
						default:     cmd.load_en = 1'b0;
					endcase
				end
			end
			S_RESULT:    cmd.res_load = st.out_free;
			S_SUM:       cmd.sum_rd = !idx_end;
			S_CHECK:     cmd.mul_ld_nq = !st.n_zero;
			S_MUL_NQ,
			S_MUL_SS:    cmd.mul_step = 1'b1;
			S_MUL_SWAP:  cmd.mul_ld_ss = 1'b1;
			S_DZERO:     cmd.sqrt_ld = !st.d_zero;
			S_MARK: begin
				cmd.wr_en = !idx_end;
				cmd.wr_src = WR_MARK;
			end
			S_SQRT:      cmd.sqrt_step = 1'b1;
			S_NORM_RD:   cmd.norm_rd = !idx_end;
			S_NORM_WAIT: cmd.prod_en = !st.rd_missing;
			S_NORM_LOAD: cmd.div_ld = 1'b1;
			S_NORM_DIV:  cmd.div_step = 1'b1;
			S_NORM_WB:   cmd.wr_en = 1'b1;
			default:     cmd.res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			step_q <= '0;
			kind_q <= RES_FULL;
		end else begin
			state_q <= state_d;
			// step count restarts on every state change
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						case (func)
							FUNC_LOAD:   kind_q <= RES_FULL;
							FUNC_FINISH: kind_q <= RES_FINISH;
							default:     kind_q <= RES_QUERY;
						endcase
					end
				end
				S_SUM, S_MARK: if (!idx_end) idx_q <= idx_q + 1'b1;
				S_CHECK:       idx_q <= '0;
				S_NORM_WAIT:   if (st.rd_missing) idx_q <= idx_q + 1'b1;
				S_NORM_WB:     idx_q <= idx_q + 1'b1;
				default:       idx_q <= idx_q;
			endcase
		end
	end

endmodule

FILE: hdl/zpd_datapath.sv
// sample store, statistics accumulators, shift-add multiplier, square root,
// divider and result register; depends on zpd_pkg, driven by zpd_ctrl
`timescale 1ns / 1ps

module zpd_datapath import zpd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  zpd_cmd_t                 cmd,
	output zpd_stat_t                st,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     sample_missing,
	input  logic [ADDR_W-1:0]        loc_a,
	input  logic [ADDR_W-1:0]        loc_b,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [DATA_W-1:0]        distance,
	output logic                     distance_missing,
	output logic [1:0]               status
);

	// each entry holds the missing mark above the sample
	logic [DATA_W:0] mem [MAX_LOCATIONS];
	logic [DATA_W:0] rd_a_q, rd_b_q;
	logic [CNT_W-1:0] count_q, eff_count;
	logic closed_q;
	logic [ADDR_W-1:0] qa_q, qb_q;

	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W:0] wr_data;
	logic rd_a_en;
	logic [ADDR_W-1:0] rd_a_addr;

	logic signed [DATA_W-1:0] va;
	logic sv_s1, sv_s2;
	logic signed [SQP_W-1:0] sq_s2;
	logic [CNT_W-1:0] n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0] sumsq_q;
	logic [SUM_W-1:0] abs_full;

	logic [D_W-1:0] macc_q, mcand_q;
	logic [ABS_W-1:0] mplier_q;
	logic msub_q;

	logic [X_W-1:0] xs_q;
	logic [SREM_W-1:0] srem_q, srem_sh, trial;
	logic [RT_W-1:0] root_q;
	logic sge;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0] num_mag;
	logic [DVD_W-1:0] dvd_q, dividend;
	logic [DREM_W-1:0] drem_q;
	logic [DREM_W:0] drem_sh;
	logic dge;
	logic [QUO_W-1:0] quo_q;
	logic qovf_q, dneg_q;
	logic [DATA_W-1:0] zscore;

	logic q_range, q_missing;
	logic signed [DATA_W:0] qdiff;
	logic [DATA_W:0] qmag;

	logic out_valid_q, dmiss_q;
	logic [DATA_W-1:0] dist_q;
	logic [1:0] stat_q;

	// a load after a finish starts a new column
	assign eff_count = closed_q ? '0 : count_q;

	assign st.load_full = eff_count == CNT_W'(MAX_LOCATIONS);
	assign st.count = count_q;
	assign st.n_zero = n_q == '0;
	assign st.d_zero = macc_q == '0;
	assign st.rd_missing = rd_a_q[DATA_W];
	assign st.out_free = !out_valid_q || !out_stall;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cmd.idx;
		wr_data = {sample_missing, sample};
		if (cmd.load_en && !st.load_full) begin
			wr_en = 1'b1;
			wr_addr = eff_count[ADDR_W-1:0];
		end else if (cmd.wr_en) begin
			wr_en = 1'b1;
			unique case (cmd.wr_src)
				WR_MARK:   wr_data = {1'b1, {DATA_W{1'b0}}};
				WR_ZSCORE: wr_data = {1'b0, zscore};
				default:   wr_data = {1'b1, {DATA_W{1'b0}}};
			endcase
		end
	end

	assign rd_a_en = cmd.query_en || cmd.sum_rd || cmd.norm_rd;
	assign rd_a_addr = cmd.query_en ? loc_a : cmd.idx;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_a_en) rd_a_q <= mem[rd_a_addr];
		if (cmd.query_en) rd_b_q <= mem[loc_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			closed_q <= 1'b0;
		end else if (cmd.load_en) begin
			closed_q <= 1'b0;
			count_q <= st.load_full ? eff_count : eff_count + 1'b1;
		end else if (cmd.close_en) begin
			closed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_en) begin
			qa_q <= loc_a;
			qb_q <= loc_b;
		end
	end

	// statistics pass: read, square, accumulate
	assign va = rd_a_q[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
			sv_s2 <= 1'b0;
		end else begin
			sv_s1 <= cmd.sum_rd;
			sv_s2 <= sv_s1 && !rd_a_q[DATA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (sv_s1) sq_s2 <= va * va;
		if (cmd.sum_clr) begin
			n_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
		end else begin
			if (sv_s1 && !rd_a_q[DATA_W]) begin
				n_q <= n_q + 1'b1;
				sum_q <= sum_q + SUM_W'(va);
			end
			if (sv_s2) sumsq_q <= sumsq_q + SQ_W'($unsigned(sq_s2));
		end
	end

	assign abs_full = sum_q[SUM_W-1] ? -sum_q : sum_q;

	// shift-add multiplier: n*Q first, then S*S subtracted
	always_ff @(posedge clk) begin
		if (cmd.mul_ld_nq) begin
			macc_q <= '0;
			mcand_q <= D_W'(sumsq_q);
			mplier_q <= ABS_W'(n_q);
			msub_q <= 1'b0;
		end else if (cmd.mul_ld_ss) begin
			mcand_q <= D_W'(abs_full[ABS_W-1:0]);
			mplier_q <= abs_full[ABS_W-1:0];
			msub_q <= 1'b1;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) macc_q <= msub_q ? macc_q - mcand_q : macc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// restoring square root of D * 2^32, two radicand bits per step
	assign srem_sh = {srem_q[SREM_W-3:0], xs_q[X_W-1 -: 2]};
	assign trial = SREM_W'({root_q, 2'b01});
	assign sge = srem_sh >= trial;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_ld) begin
			xs_q <= X_W'({macc_q, {DATA_W{1'b0}}});
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= sge ? srem_sh - trial : srem_sh;
			root_q <= {root_q[RT_W-2:0], sge};
			xs_q <= xs_q << 2;
		end
	end

	// z numerator n*v - S, rounded quotient by the root
	assign num = NUM_W'(prod_s1) - NUM_W'(sum_q);
	assign num_mag = num[NUM_W-1] ? -num : num;
	assign dividend = DVD_W'({num_mag[MAG_W-1:0], {DATA_W{1'b0}}}) + DVD_W'(root_q >> 1);
	assign drem_sh = {drem_q, dvd_q[DVD_W-1]};
	assign dge = drem_sh >= (DREM_W + 1)'(root_q);

	always_ff @(posedge clk) begin
		if (cmd.prod_en) prod_s1 <= $signed({1'b0, n_q}) * va;
		if (cmd.div_ld) begin
			dvd_q <= dividend;
			drem_q <= '0;
			quo_q <= '0;
			qovf_q <= 1'b0;
			dneg_q <= num[NUM_W-1];
		end else if (cmd.div_step) begin
			drem_q <= dge ? DREM_W'(drem_sh - (DREM_W + 1)'(root_q)) : DREM_W'(drem_sh);
			// quotient bits beyond the saturation range only matter as a sticky flag
			qovf_q <= qovf_q | quo_q[QUO_W-1];
			quo_q <= {quo_q[QUO_W-2:0], dge};
			dvd_q <= dvd_q << 1;
		end
	end

	always_comb begin
		if (dneg_q) begin
			zscore = (qovf_q || quo_q > QUO_W'(Z_NEG_MAX)) ? Z_NEG_MAX
				: -quo_q[DATA_W-1:0];
		end else begin
			zscore = (qovf_q || quo_q > QUO_W'(Z_POS_MAX)) ? Z_POS_MAX
				: quo_q[DATA_W-1:0];
		end
	end

	// query result from the two registered reads
	assign q_range = ({1'b0, qa_q} >= count_q) || ({1'b0, qb_q} >= count_q);
	assign q_missing = rd_a_q[DATA_W] || rd_b_q[DATA_W];
	assign qdiff = $signed({rd_a_q[DATA_W-1], rd_a_q[DATA_W-1:0]})
		- $signed({rd_b_q[DATA_W-1], rd_b_q[DATA_W-1:0]});
	assign qmag = qdiff[DATA_W] ? -qdiff : qdiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			dist_q <= '0;
			dmiss_q <= 1'b0;
			stat_q <= ST_OK;
			unique case (cmd.res_kind)
				RES_FULL:   stat_q <= ST_FULL;
				RES_FINISH: dist_q <= DATA_W'(count_q);
				RES_QUERY: begin
					if (q_range) stat_q <= ST_RANGE;
					else if (q_missing) dmiss_q <= 1'b1;
					else dist_q <= qmag[DATA_W-1:0];
				end
				default:    stat_q <= ST_OK;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign distance = dist_q;
	assign distance_missing = dmiss_q;
	assign status = stat_q;

endmodule

FILE: hdl/zpd_checker.sv
// port-level checks of the z-score distance block, bound to the top level
// depends on zpd_pkg and zscore_pairwise_distance_macros.svh
`timescale 1ns / 1ps
`include "zscore_pairwise_distance_macros.svh"

module zpd_checker import zpd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [1:0]               func,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [DATA_W-1:0]        distance,
	input logic                     distance_missing,
	input logic [1:0]               status
);

	`ZPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance) && $stable(status) && $stable(distance_missing))
	`ZPD_ASSERT(a_err_no_data, (out_valid && status != ST_OK) |-> (distance == '0 && !distance_missing))
	`ZPD_ASSERT(a_miss_no_data, (out_valid && distance_missing) |-> (distance == '0 && status == ST_OK))
	`ZPD_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && func == FUNC_QUERY, in_stall)
	`ZPD_ASSERT_NEXT(a_finish_busy, in_valid && !in_stall && func == FUNC_FINISH, in_stall)

endmodule

bind zscore_pairwise_distance zpd_checker u_zpd_checker (.*);

FILE: tb/tb_zscore_pairwise_distance.sv
// testbench for the z-score pairwise distance block: directed and random column traffic
// checks every result against an in-bench predictor; depends on zpd_pkg and the block
`timescale 1ns / 1ps

module tb_zscore_pairwise_distance;
	import zpd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [31:0] dval;
		logic        miss;
		logic [1:0]  stat;
	} dist_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_NOP;
	logic signed [31:0] sample = '0;
	logic sample_missing = 1'b0;
	logic [ADDR_W-1:0] loc_a = '0;
	logic [ADDR_W-1:0] loc_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] distance;
	logic distance_missing;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	zscore_pairwise_distance u_dut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [31:0] col_values [MAX_LOCATIONS];
	bit col_missing [MAX_LOCATIONS];
	int col_count = 0;
	bit col_closed = 0;
	bit norm_on = 0;

	dist_result_t expected_dist_q [$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_phase = 0;
	int stall_mode = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: own stall pattern plus an occasional long hold-off
	always @(posedge clk) begin
		dist_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_dist_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: dist %h miss %b status %0d",
						distance, distance_missing, status);
			end else begin
				e = expected_dist_q.pop_front();
				if (e.dval !== distance || e.miss !== distance_missing ||
						e.stat !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%b/%0d got %h/%b/%0d", e.dval, e.miss,
							e.stat, distance, distance_missing, status);
				end
			end
		end
		if (hold_req) begin
			hold_req = 0;
			hold_left = 600;
		end
		stall_phase++;
		if (stall_phase % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				2: out_stall <= (stall_phase % 3 == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	function automatic void zscore_column();
		longint n, s, v, num;
		logic [127:0] sq_acc, dev, shifted, nw, quo;
		logic [63:0] root, cand, mag;
		n = 0;
		s = 0;
		sq_acc = '0;
		for (int i = 0; i < col_count; i++) begin
			if (!col_missing[i]) begin
				v = longint'(signed'(col_values[i]));
				n++;
				s += v;
				sq_acc += 128'(v * v);
			end
		end
		if (n == 0)
			return;
		mag = (s < 0) ? 64'(-s) : 64'(s);
		dev = sq_acc * 128'(n) - 128'(mag) * 128'(mag);
		if (dev == 0) begin
			for (int i = 0; i < col_count; i++)
				col_missing[i] = 1;
			return;
		end
		shifted = dev << 32;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= shifted)
				root = cand;
		end
		if (root == 0)
			root = 1;
		for (int i = 0; i < col_count; i++) begin
			if (!col_missing[i]) begin
				num = n * longint'(signed'(col_values[i])) - s;
				mag = (num < 0) ? 64'(-num) : 64'(num);
				nw = (128'(mag) << 32) + 128'(root >> 1);
				quo = nw / 128'(root);
				if (num < 0)
					col_values[i] = (quo > 128'h8000_0000) ? Z_NEG_MAX : -quo[31:0];
				else
					col_values[i] = (quo > 128'h7FFF_FFFF) ? Z_POS_MAX : quo[31:0];
			end
		end
	endfunction

	function automatic void predict_item(logic [1:0] f, logic [31:0] smp, bit m,
			int a, int b);
		dist_result_t r;
		longint diff;
		r.dval = '0;
		r.miss = 1'b0;
		r.stat = ST_OK;
		case (f)
			FUNC_LOAD: begin
				if (col_closed) begin
					col_count = 0;
					col_closed = 0;
				end
				if (col_count >= MAX_LOCATIONS) begin
					r.stat = ST_FULL;
					expected_dist_q.push_back(r);
				end else begin
					col_values[col_count] = smp;
					col_missing[col_count] = m;
					col_count++;
				end
			end
			FUNC_FINISH: begin
				if (norm_on)
					zscore_column();
				col_closed = 1;
				r.dval = 32'(col_count);
				expected_dist_q.push_back(r);
			end
			FUNC_QUERY: begin
				if (a >= col_count || b >= col_count)
					r.stat = ST_RANGE;
				else if (col_missing[a] || col_missing[b])
					r.miss = 1'b1;
				else begin
					diff = longint'(signed'(col_values[a])) - longint'(signed'(col_values[b]));
					if (diff < 0)
						diff = -diff;
					r.dval = (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
				end
				expected_dist_q.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the item was taken
	task automatic send_item(logic [1:0] f, logic [31:0] smp = '0, bit m = 0,
			int a = 0, int b = 0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		sample <= smp;
		sample_missing <= m;
		loc_a <= ADDR_W'(a);
		loc_b <= ADDR_W'(b);
		do @(posedge clk); while (in_stall);
		predict_item(f, smp, m, a, b);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_dist_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_normalize(bit val);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= CFG_NORM_ADDR;
		pwdata <= {31'($urandom_range(0, 32'h7FFF_FFFF)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		norm_on = val;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed_raw();
		write_normalize(0);
		send_item(FUNC_QUERY, 0, 0, 0, 0);
		send_item(FUNC_LOAD, 32'h8000_0000, 0);
		send_item(FUNC_LOAD, 32'h7FFF_FFFF, 0);
		send_item(FUNC_LOAD, 32'h0000_0000, 1);
		send_item(FUNC_LOAD, 32'hFFFF_FFFF, 0);
		send_item(FUNC_QUERY, 0, 0, 0, 1);
		send_item(FUNC_QUERY, 0, 0, 1, 0);
		send_item(FUNC_QUERY, 0, 0, 3, 3);
		send_item(FUNC_QUERY, 0, 0, 2, 1);
		send_item(FUNC_QUERY, 0, 0, 4, 0);
		send_item(FUNC_QUERY, 0, 0, 0, 1023);
		send_item(FUNC_NOP, 32'hFFFF_FFFF, 1, 1023, 1023);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 3, 1);
		send_item(FUNC_LOAD, 32'h0001_0000, 0);
		send_item(FUNC_QUERY, 0, 0, 1, 0);
	endtask

	task automatic test_directed_zscore();
		write_normalize(1);
		// zero deviation: equal samples all end up missing
		send_item(FUNC_LOAD, 32'h0003_0000, 0);
		send_item(FUNC_LOAD, 32'h0003_0000, 1);
		send_item(FUNC_LOAD, 32'h0003_0000, 0);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 0, 2);
		// every sample missing: store left alone
		send_item(FUNC_LOAD, 32'h0001_0000, 1);
		send_item(FUNC_LOAD, 32'h0002_0000, 1);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 0, 1);
		// extremes, then a second finish normalizes again
		send_item(FUNC_LOAD, 32'h8000_0000, 0);
		send_item(FUNC_LOAD, 32'h7FFF_FFFF, 0);
		send_item(FUNC_LOAD, 32'h0000_1234, 0);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 0, 1);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 2, 0);
		// a third finish normalizes the same closed column once more
		send_item(FUNC_FINISH);
	endtask

	task automatic test_full_store();
		write_normalize(1'($urandom_range(0, 1)));
		for (int i = 0; i < MAX_LOCATIONS; i++)
			send_item(FUNC_LOAD, pick_sample(), ($urandom_range(0, 7) == 0));
		send_item(FUNC_LOAD, 32'h1234_5678, 0);
		send_item(FUNC_QUERY, 0, 0, 1023, 0);
		send_item(FUNC_FINISH);
		send_item(FUNC_QUERY, 0, 0, 1023, 512);
	endtask

	task automatic test_random_columns(int budget, bit with_hold);
		int sent, len, nq;
		bit held;
		sent = 0;
		held = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				send_item(FUNC_LOAD, pick_sample(), ($urandom_range(0, 5) == 0));
			sent += len;
			if (with_hold && !held && sent > budget / 2) begin
				hold_req = 1;
				held = 1;
			end
			nq = $urandom_range(0, 4);
			for (int i = 0; i < nq; i++)
				send_item(FUNC_QUERY, $urandom(), 1'($urandom_range(0, 1)),
					$urandom_range(0, len - 1), $urandom_range(0, len - 1));
			send_item(FUNC_FINISH, $urandom(), 1'($urandom_range(0, 1)),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
			nq = $urandom_range(1, 6);
			for (int i = 0; i < nq; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(FUNC_QUERY, $urandom(), 0, $urandom_range(0, 1023),
						$urandom_range(0, 1023));
				else
					send_item(FUNC_QUERY, 0, 0, $urandom_range(0, len - 1),
						$urandom_range(0, len - 1));
			end
			if ($urandom_range(0, 4) == 0)
				send_item(FUNC_NOP, $urandom(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			if ($urandom_range(0, 9) == 0)
				send_item(FUNC_FINISH);
			sent += nq + 3;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_raw();
		test_directed_zscore();
		test_random_columns(180, 1);
		write_normalize(0);
		test_random_columns(180, 0);
		write_normalize(1);
		test_random_columns(150, 0);
		test_full_store();
		wait_idle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// config access must never be held off
	always @(posedge clk) begin
		if (psel && penable && !pready && arst_n)
			mismatches++;
	end

endmodule

FILE: zscore_pairwise_distance.f
+incdir+hdl
hdl/zpd_pkg.sv
hdl/zpd_ctrl.sv
hdl/zpd_datapath.sv
hdl/zscore_pairwise_distance.sv
hdl/zpd_checker.sv
tb/tb_zscore_pairwise_distance.sv
